### rtl/core/sae_pkg.sv
// ----------------------------------------------------------------------------
// sae_pkg: shared types and constants of the stack allocator engine
// Request and result word layouts, status and mode codes, sizing constants
// and the controller-to-datapath command and status groups.
// ----------------------------------------------------------------------------
package sae_pkg;

	localparam int BUFFER_BYTES   = 4096;
	localparam int HEADER_BYTES   = 16;
	localparam int MAX_ALIGN_LOG2 = 7;
	localparam int MEM_AW         = $clog2(BUFFER_BYTES);
	localparam int OFF_W          = 13;
	localparam int PAD_W          = 9;
	localparam int SUM_W          = 14;

	// request modes
	localparam logic [1:0] MODE_ALLOC    = 2'd0;
	localparam logic [1:0] MODE_FREE     = 2'd1;
	localparam logic [1:0] MODE_RESIZE   = 2'd2;
	localparam logic [1:0] MODE_FREE_ALL = 2'd3;

	// result status codes
	localparam logic [2:0] STAT_OK     = 3'd0;
	localparam logic [2:0] STAT_OOM    = 3'd1;
	localparam logic [2:0] STAT_BOUNDS = 3'd2;
	localparam logic [2:0] STAT_STALE  = 3'd3;
	localparam logic [2:0] STAT_ORDER  = 3'd4;

	// configuration register indexes
	localparam logic CFG_BUFFER_LENGTH = 1'b0;
	localparam logic CFG_BASE_LOW_BITS = 1'b1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [11:0] address;
		logic        address_null;
		logic [12:0] alloc_size;
		logic [12:0] cur_size;
		logic [3:0]  alignment_log2;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        block_valid;
		logic [11:0] block_offset;
		logic [12:0] copy_length;
		logic [11:0] copy_from;
	} rsp_t;

	// block header: previous offset in bits 20..8, padding in bits 7..0
	typedef struct packed {
		logic [OFF_W-1:0] prev;
		logic [7:0]       pad;
	} hdr_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic clear;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
	} ctrl_sts_t;

endpackage

### rtl/core/stack_allocator_engine.sv
// ----------------------------------------------------------------------------
// stack_allocator_engine: LIFO stack allocator with alignment headers
// Allocates, frees and resizes blocks in a byte buffer, keeping a header
// (padding and previous offset) per block in an on-chip header store.
// ----------------------------------------------------------------------------
//
//  channel   handshake              word / fields
//  --------  ---------------------  -----------------------------------------
//  request   start, busy            req  : mode, address, address_null,
//                                          alloc_size, cur_size, alignment_log2
//  result    done (1-cycle strobe)  rsp  : status, block_valid, block_offset,
//                                          copy_length, copy_from
//  config    cfg_valid, cfg_ready   cfg_index (0 length, 1 base bits), cfg_data
//
//  A request word is taken when start is high and busy is low; the header
//  entry at its address is read on that same edge.
//  The execute state follows, with busy high: padding, bounds and order
//  checks, the header write and the offset update all happen there, and the
//  result register loads at its end.
//  The result shows on rsp with done high for one cycle while busy is
//  already low, so the next word can be taken in that cycle.
//  After reset the header store is swept to zero, one entry a cycle, with
//  busy high until every entry is cleared. Config writes are always
//  taken and must only happen while the engine is idle.
//  The result side has no backpressure; sample rsp whenever done is high.
//
module stack_allocator_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sae_pkg::req_t     req,
	output logic              done,
	output sae_pkg::rsp_t     rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [12:0]       cfg_data
);

	sae_pkg::ctrl_cmd_t cmd;
	sae_pkg::ctrl_sts_t sts;

	// config writes never stall
	assign cfg_ready = 1'b1;

	// sequencer: clear sweep, accept, execute
	sae_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	// offsets, header store, checks and result register
	sae_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

### rtl/core/sae_ctrl.sv
// ----------------------------------------------------------------------------
// sae_ctrl: sequencer of the stack allocator engine
// Walks the header clear after reset, then accepts one request word and
// runs it in the execute state.
// ----------------------------------------------------------------------------
module sae_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	output sae_pkg::ctrl_cmd_t    cmd,
	input  sae_pkg::ctrl_sts_t    sts
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_EXEC);
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign cmd.capture = start && (state_q == S_IDLE);
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.clear   = (state_q == S_CLEAR);

`ifndef SYNTHESIS
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> done)
		else $error("execute cycle gave no result");
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_EXEC))
		else $error("accepted word did not execute");
	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |=> (state_q == S_CLEAR || state_q == S_IDLE))
		else $error("clear left for a bad state");
`endif

endmodule

### rtl/core/sae_datapath.sv
// ----------------------------------------------------------------------------
// sae_datapath: offsets, header store and result register
// Holds top and previous top, the configuration registers and the header
// memory; computes alignment padding and free checks in the execute cycle.
// ----------------------------------------------------------------------------
module sae_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sae_pkg::req_t          req,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [12:0]            cfg_data,
	input  sae_pkg::ctrl_cmd_t     cmd,
	output sae_pkg::ctrl_sts_t     sts,
	output sae_pkg::rsp_t          rsp
);

	localparam int AW  = sae_pkg::MEM_AW;
	localparam int OW  = sae_pkg::OFF_W;
	localparam int PW  = sae_pkg::PAD_W;
	localparam int SW  = sae_pkg::SUM_W;

	sae_pkg::hdr_t   mem [sae_pkg::BUFFER_BYTES];
	sae_pkg::hdr_t   rd_q;
	sae_pkg::req_t   req_q;
	sae_pkg::rsp_t   rsp_q;
	sae_pkg::rsp_t   rsp_d;
	logic [OW-1:0]   top_q;
	logic [OW-1:0]   prev_top_q;
	logic [12:0]     buf_len_q;
	logic [6:0]      base_q;
	logic [AW-1:0]   clr_q;

	logic [OW-1:0]   eff_len;
	logic [2:0]      lg;
	logic [PW-1:0]   align;
	logic [PW-1:0]   amask;
	logic [OW-1:0]   abs_top;
	logic [PW-1:0]   modulo;
	logic [PW-1:0]   pad0;
	logic [PW-1:0]   need;
	logic [PW-1:0]   pad;
	logic [SW-1:0]   blk_start;
	logic [SW-1:0]   blk_end;
	logic            alloc_ok;
	logic [2:0]      live_st;
	logic [2:0]      free_st;
	logic            order_ok;
	logic            commit_alloc;
	logic            commit_free;
	logic            commit_clear_all;

	// effective length and alignment clamp
	assign eff_len = (buf_len_q > OW'(sae_pkg::BUFFER_BYTES)) ?
		OW'(sae_pkg::BUFFER_BYTES) : buf_len_q;
	assign lg = (req_q.alignment_log2 > 4'(sae_pkg::MAX_ALIGN_LOG2)) ?
		3'(sae_pkg::MAX_ALIGN_LOG2) : req_q.alignment_log2[2:0];
	assign align = PW'(1) << lg;
	assign amask = align - PW'(1);

	// padding: align the block, then round up until the header fits
	assign abs_top = OW'(base_q) + top_q;
	assign modulo  = PW'(abs_top[7:0]) & amask;
	assign pad0    = (modulo != '0) ? (align - modulo) : '0;
	assign need    = PW'(sae_pkg::HEADER_BYTES) - pad0;
	assign pad     = (pad0 < PW'(sae_pkg::HEADER_BYTES)) ?
		(pad0 + ((need + amask) & ~amask)) : pad0;

	assign blk_start = SW'(top_q) + SW'(pad);
	assign blk_end   = blk_start + SW'(req_q.alloc_size);
	assign alloc_ok  = (blk_end <= SW'(eff_len)) &&
		(blk_start < SW'(sae_pkg::BUFFER_BYTES));

	// free checks against the header read at accept
	assign live_st = (OW'(req_q.address) >= eff_len) ? sae_pkg::STAT_BOUNDS :
		(OW'(req_q.address) >= top_q) ? sae_pkg::STAT_STALE : sae_pkg::STAT_OK;
	assign order_ok = ((OW'(req_q.address) - OW'(rd_q.pad)) == rd_q.prev);
	assign free_st  = (live_st != sae_pkg::STAT_OK) ? live_st :
		order_ok ? sae_pkg::STAT_OK : sae_pkg::STAT_ORDER;

	always_comb begin
		commit_alloc     = 1'b0;
		commit_free      = 1'b0;
		commit_clear_all = 1'b0;
		rsp_d            = '0;
		case (req_q.mode)
			sae_pkg::MODE_ALLOC: begin
				if (alloc_ok) begin
					commit_alloc       = 1'b1;
					rsp_d.block_valid  = 1'b1;
					rsp_d.block_offset = blk_start[11:0];
				end else begin
					rsp_d.status = sae_pkg::STAT_OOM;
				end
			end
			sae_pkg::MODE_FREE: begin
				if (!req_q.address_null) begin
					rsp_d.status = free_st;
					commit_free  = (free_st == sae_pkg::STAT_OK);
				end
			end
			sae_pkg::MODE_RESIZE: begin
				if (req_q.address_null) begin
					if (alloc_ok) begin
						commit_alloc       = 1'b1;
						rsp_d.block_valid  = 1'b1;
						rsp_d.block_offset = blk_start[11:0];
					end else begin
						rsp_d.status = sae_pkg::STAT_OOM;
					end
				end else if (req_q.alloc_size == '0) begin
					rsp_d.status = free_st;
					commit_free  = (free_st == sae_pkg::STAT_OK);
				end else if (live_st != sae_pkg::STAT_OK) begin
					rsp_d.status = live_st;
				end else if (req_q.cur_size == req_q.alloc_size) begin
					rsp_d.block_valid  = 1'b1;
					rsp_d.block_offset = req_q.address;
				end else if (alloc_ok) begin
					commit_alloc       = 1'b1;
					rsp_d.block_valid  = 1'b1;
					rsp_d.block_offset = blk_start[11:0];
					rsp_d.copy_length  = (req_q.cur_size < req_q.alloc_size) ?
						req_q.cur_size : req_q.alloc_size;
					rsp_d.copy_from    = req_q.address;
				end else begin
					rsp_d.status = sae_pkg::STAT_OOM;
				end
			end
			sae_pkg::MODE_FREE_ALL: begin
				commit_clear_all = 1'b1;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	// control and offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q      <= '0;
			prev_top_q <= '0;
			buf_len_q  <= 13'(sae_pkg::BUFFER_BYTES);
			base_q     <= '0;
			clr_q      <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == sae_pkg::CFG_BUFFER_LENGTH) begin
					buf_len_q <= cfg_data;
				end else begin
					base_q <= cfg_data[6:0];
				end
			end
			if (cmd.clear) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.exec) begin
				if (commit_alloc) begin
					prev_top_q <= top_q;
					top_q      <= blk_end[OW-1:0];
				end else if (commit_free) begin
					top_q      <= prev_top_q;
					prev_top_q <= rd_q.prev;
				end else if (commit_clear_all) begin
					top_q <= '0;
				end
			end
		end
	end

	// request and result words
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	// header store: one write port, one registered read at accept
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			mem[clr_q] <= '0;
		end else if (cmd.exec && commit_alloc) begin
			mem[blk_start[AW-1:0]] <= '{prev: top_q, pad: pad[7:0]};
		end
		if (cmd.capture) begin
			rd_q <= mem[req.address[AW-1:0]];
		end
	end

	assign sts.clear_last = &clr_q;
	assign rsp            = rsp_q;

`ifndef SYNTHESIS
	a_copy_has_block: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.exec) |-> (rsp_q.copy_length == '0 || rsp_q.block_valid))
		else $error("copy reported without a block");
	a_alloc_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && commit_alloc) |=> (top_q > prev_top_q))
		else $error("allocation did not raise the top");
	a_one_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> $onehot0({commit_alloc, commit_free, commit_clear_all}))
		else $error("more than one state update");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stack allocator engine verification
// Drives allocate, free, resize and free-all words through the start/busy
// port, keeps a shadow of the stack top, the previous top and the header
// store, and checks every result word against the shadow's prediction.
// Runs several buffer length / base alignment settings, directed corners
// first, then mostly well-formed random traffic, with bursty idle gaps in most phases.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 162;

	typedef struct packed {
		logic [11:0] off;
		logic [12:0] size;
	} live_block_t;

	// DUT ports; every input is known from time zero
	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          start     = 1'b0;
	logic          busy;
	sae_pkg::req_t req       = '0;
	logic          done;
	sae_pkg::rsp_t rsp;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic          cfg_index = 1'b0;
	logic [12:0]   cfg_data  = '0;

	// shadow of the allocator state and its two registers
	logic [12:0]   shadow_top;
	logic [12:0]   shadow_prev;
	sae_pkg::hdr_t shadow_hdr [sae_pkg::BUFFER_BYTES];
	logic [12:0]   shadow_len;
	logic [6:0]    shadow_base;

	sae_pkg::rsp_t pending_outcomes [$];
	live_block_t   live_blocks [$];
	sae_pkg::rsp_t want_rsp;
	int            mismatch_count = 0;
	int            result_count   = 0;
	int unsigned   cycle_count    = 0;
	bit            gaps_on        = 1'b1;

	stack_allocator_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// watchdog: a hung handshake or a lost result ends the run here
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// shadow model of the allocator
	// ------------------------------------------------------------------

	// buffer lengths above the physical buffer act as the full buffer
	function automatic int usable_length();
		return (int'(shadow_len) > sae_pkg::BUFFER_BYTES) ?
			sae_pkg::BUFFER_BYTES : int'(shadow_len);
	endfunction

	// padding in front of a block: round up to the alignment, then add whole
	// alignment steps until the header fits
	function automatic int header_padding(input int where, input int align);
		int modulo;
		int pad;
		int need;
		modulo = where & (align - 1);
		pad    = (modulo != 0) ? align - modulo : 0;
		if (pad < sae_pkg::HEADER_BYTES) begin
			need = sae_pkg::HEADER_BYTES - pad;
			pad += align * ((need + align - 1) / align);
		end
		return pad;
	endfunction

	function automatic logic [2:0] shadow_alloc(input int size, input int lg_req,
		output int blk);
		int lg;
		int align;
		int pad;
		int first;
		lg    = (lg_req > sae_pkg::MAX_ALIGN_LOG2) ? sae_pkg::MAX_ALIGN_LOG2 : lg_req;
		align = 1 << lg;
		pad   = header_padding(int'(shadow_base) + int'(shadow_top), align);
		first = int'(shadow_top) + pad;
		blk   = 0;
		// refuse overflow, and a zero-size block that would start at or past the buffer end
		if (first + size > usable_length() || first >= sae_pkg::BUFFER_BYTES)
			return sae_pkg::STAT_OOM;
		shadow_prev            = shadow_top;
		shadow_hdr[first].pad  = pad[7:0];
		shadow_hdr[first].prev = shadow_prev;
		shadow_top             = 13'(first + size);
		blk                    = first;
		return sae_pkg::STAT_OK;
	endfunction

	function automatic logic [2:0] shadow_live(input int addr);
		if (addr >= usable_length())
			return sae_pkg::STAT_BOUNDS;
		if (addr >= int'(shadow_top))
			return sae_pkg::STAT_STALE;
		return sae_pkg::STAT_OK;
	endfunction

	function automatic logic [2:0] shadow_free(input int addr);
		logic [2:0]    st;
		sae_pkg::hdr_t h;
		st = shadow_live(addr);
		if (st != sae_pkg::STAT_OK)
			return st;
		h = shadow_hdr[addr];
		// the header must point back to where the block's padding began
		if (((addr - int'(h.pad)) & 'h1FFF) != int'(h.prev))
			return sae_pkg::STAT_ORDER;
		shadow_top  = shadow_prev;
		shadow_prev = h.prev;
		return sae_pkg::STAT_OK;
	endfunction

	// advance the shadow by one request word and return its result word
	function automatic sae_pkg::rsp_t allocator_outcome(input sae_pkg::req_t w);
		sae_pkg::rsp_t r;
		logic [2:0]    st;
		int            blk;
		r   = '0;
		st  = sae_pkg::STAT_OK;
		blk = 0;
		case (w.mode)
			sae_pkg::MODE_ALLOC: begin
				st            = shadow_alloc(w.alloc_size, w.alignment_log2, blk);
				r.block_valid = (st == sae_pkg::STAT_OK);
			end
			sae_pkg::MODE_FREE: begin
				if (!w.address_null)
					st = shadow_free(w.address);
			end
			sae_pkg::MODE_RESIZE: begin
				if (w.address_null) begin
					st            = shadow_alloc(w.alloc_size, w.alignment_log2, blk);
					r.block_valid = (st == sae_pkg::STAT_OK);
				end else if (w.alloc_size == 0) begin
					st = shadow_free(w.address);
				end else begin
					st = shadow_live(w.address);
					if (st == sae_pkg::STAT_OK) begin
						if (w.cur_size == w.alloc_size) begin
							blk           = w.address;
							r.block_valid = 1'b1;
						end else begin
							st = shadow_alloc(w.alloc_size, w.alignment_log2, blk);
							if (st == sae_pkg::STAT_OK) begin
								r.block_valid = 1'b1;
								r.copy_length = (w.cur_size < w.alloc_size) ?
									w.cur_size : w.alloc_size;
								r.copy_from   = w.address;
							end
						end
					end
				end
			end
			default: begin
				shadow_top = '0;
			end
		endcase
		r.status = st;
		if (r.block_valid)
			r.block_offset = blk[11:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// result checker: the engine cannot be held off, so sample every strobe
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			result_count <= result_count + 1;
			if (pending_outcomes.size() == 0) begin
				if (mismatch_count < 10)
					$display("result %0d: unexpected word, status %0d valid %0d offset %0d",
						result_count, rsp.status, rsp.block_valid, rsp.block_offset);
				mismatch_count <= mismatch_count + 1;
			end else begin
				want_rsp = pending_outcomes.pop_front();
				if (rsp.status !== want_rsp.status ||
					rsp.block_valid !== want_rsp.block_valid ||
					rsp.block_offset !== want_rsp.block_offset ||
					rsp.copy_length !== want_rsp.copy_length ||
					rsp.copy_from !== want_rsp.copy_from) begin
					if (mismatch_count < 10) begin
						$display("result %0d mismatch (expected / actual):", result_count);
						$display("  status %0d / %0d  block_valid %0d / %0d",
							want_rsp.status, rsp.status,
							want_rsp.block_valid, rsp.block_valid);
						$display("  block_offset %0d / %0d  copy_length %0d / %0d",
							want_rsp.block_offset, rsp.block_offset,
							want_rsp.copy_length, rsp.copy_length);
						$display("  copy_from %0d / %0d", want_rsp.copy_from, rsp.copy_from);
					end
					mismatch_count <= mismatch_count + 1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers; each task returns just after a rising edge
	// ------------------------------------------------------------------

	function automatic sae_pkg::req_t request_word(input logic [1:0] mode, input int addr,
		input logic is_null, input int new_sz, input int old_sz, input int lg);
		sae_pkg::req_t w;
		w.mode           = mode;
		w.address        = addr[11:0];
		w.address_null   = is_null;
		w.alloc_size     = new_sz[12:0];
		w.cur_size       = old_sz[12:0];
		w.alignment_log2 = lg[3:0];
		return w;
	endfunction

	function automatic int newest_block();
		return (live_blocks.size() != 0) ? int'(live_blocks[$].off) : 0;
	endfunction

	// send one request word, with an optional idle burst in front of it
	task automatic send_word(input sae_pkg::req_t w);
		sae_pkg::rsp_t r;
		live_block_t   b;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		// keep start high between back-to-back words; only the word changes
		start <= 1'b1;
		req   <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = allocator_outcome(w);
		pending_outcomes.push_back(r);
		if (r.block_valid) begin
			b.off  = r.block_offset;
			b.size = w.alloc_size;
			live_blocks.push_back(b);
			if (live_blocks.size() > 16)
				void'(live_blocks.pop_front());
		end
	endtask

	// drop start and hold until every outstanding result has come back
	task automatic hold_until_drained();
		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	// drain, let the engine settle, and wait out any header sweep
	task automatic quiesce_for_config();
		hold_until_drained();
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// write both registers back to back, valid held high across the two words
	task automatic set_config(input logic [12:0] len, input logic [12:0] base_data);
		cfg_valid <= 1'b1;
		cfg_index <= sae_pkg::CFG_BUFFER_LENGTH;
		cfg_data  <= len;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		shadow_len <= len;
		cfg_index  <= sae_pkg::CFG_BASE_LOW_BITS;
		cfg_data   <= base_data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		shadow_base <= base_data[6:0];
		cfg_valid   <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset values, alignment clamping, overflow and the null, order, stale and ok frees
	task automatic test_alloc_free();
		send_word(request_word(sae_pkg::MODE_FREE_ALL, 4095, 1'b1, 4096, 4096, 15));
		send_word(request_word(sae_pkg::MODE_ALLOC, 0, 1'b0, 0, 0, 0));
		send_word(request_word(sae_pkg::MODE_ALLOC, 4095, 1'b1, 100, 0, 7));
		send_word(request_word(sae_pkg::MODE_ALLOC, 0, 1'b0, 5, 4096, 15));
		send_word(request_word(sae_pkg::MODE_ALLOC, 0, 1'b0, 4096, 0, 0));
		// null free does nothing
		send_word(request_word(sae_pkg::MODE_FREE, 4095, 1'b1, 0, 0, 0));
		// below the top but with a blank header: out of order
		send_word(request_word(sae_pkg::MODE_FREE, 200, 1'b0, 0, 0, 0));
		// at or above the top: stale
		send_word(request_word(sae_pkg::MODE_FREE, 4000, 1'b0, 0, 0, 0));
		send_word(request_word(sae_pkg::MODE_FREE, newest_block(), 1'b0, 0, 0, 0));
	endtask

	// resize paths: null, equal size, move, failed move, stale, to zero
	task automatic test_resize();
		int blk;
		send_word(request_word(sae_pkg::MODE_RESIZE, 0, 1'b1, 40, 0, 3));
		blk = newest_block();
		send_word(request_word(sae_pkg::MODE_RESIZE, blk, 1'b0, 40, 40, 3));
		send_word(request_word(sae_pkg::MODE_RESIZE, blk, 1'b0, 60, 40, 4));
		send_word(request_word(sae_pkg::MODE_RESIZE, blk, 1'b0, 4096, 40, 0));
		send_word(request_word(sae_pkg::MODE_RESIZE, 3000, 1'b0, 10, 10, 0));
		send_word(request_word(sae_pkg::MODE_RESIZE, newest_block(), 1'b0, 0, 60, 0));
	endtask

	// end of buffer, out of bounds and empty buffer
	task automatic test_buffer_edges();
		send_word(request_word(sae_pkg::MODE_FREE_ALL, 0, 1'b0, 0, 0, 0));
		// fill to 16 bytes short of the end, then a zero-size block would start at the end
		send_word(request_word(sae_pkg::MODE_ALLOC, 0, 1'b0, 4064, 0, 0));
		send_word(request_word(sae_pkg::MODE_ALLOC, 0, 1'b0, 0, 0, 4));
		quiesce_for_config();
		set_config(13'd200, 13'd5);
		send_word(request_word(sae_pkg::MODE_FREE_ALL, 0, 1'b0, 0, 0, 0));
		send_word(request_word(sae_pkg::MODE_FREE, 300, 1'b0, 0, 0, 0));
		send_word(request_word(sae_pkg::MODE_RESIZE, 300, 1'b0, 5, 9, 0));
		send_word(request_word(sae_pkg::MODE_ALLOC, 0, 1'b0, 0, 0, 0));
		quiesce_for_config();
		set_config(13'd0, 13'd127);
		send_word(request_word(sae_pkg::MODE_ALLOC, 0, 1'b0, 0, 0, 0));
		quiesce_for_config();
		// length above the buffer acts as the full buffer; base uses low bits only
		set_config(13'h1FFF, 13'h1FFF);
		send_word(request_word(sae_pkg::MODE_FREE_ALL, 0, 1'b0, 0, 0, 0));
	endtask

	// mostly well-formed allocate/free/resize traffic on live blocks, some noise
	task automatic test_random_traffic(input int count, input bit allow_gaps);
		sae_pkg::req_t w;
		live_block_t   b;
		int            roll;
		int            pick;
		for (int n = 0; n < count; n++) begin
			if (n % 64 == 0)
				gaps_on = allow_gaps && ($urandom_range(0, 2) != 0);
			if (n == count / 2)
				hold_until_drained();
			w.address        = 12'($urandom_range(0, 4095));
			w.address_null   = ($urandom_range(0, 15) == 0);
			w.cur_size       = 13'($urandom_range(0, 4096));
			w.alignment_log2 = 4'($urandom_range(0, 15));
			pick = $urandom_range(0, 19);
			if (pick == 0)
				w.alloc_size = '0;
			else if (pick == 1)
				w.alloc_size = 13'($urandom_range(0, 4096));
			else if (pick == 2)
				w.alloc_size = 13'd4096;
			else
				w.alloc_size = 13'($urandom_range(1, 64));
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				w.mode = sae_pkg::MODE_ALLOC;
			end else if (roll < 65) begin
				w.mode = sae_pkg::MODE_FREE;
				if (live_blocks.size() != 0 && $urandom_range(0, 3) != 0) begin
					w.address      = live_blocks[$].off;
					w.address_null = 1'b0;
					void'(live_blocks.pop_back());
				end
			end else if (roll < 92) begin
				w.mode = sae_pkg::MODE_RESIZE;
				if (live_blocks.size() != 0 && $urandom_range(0, 3) != 0) begin
					b              = live_blocks.pop_back();
					w.address      = b.off;
					w.cur_size     = b.size;
					w.address_null = 1'b0;
					pick = $urandom_range(0, 7);
					if (pick < 2)
						w.alloc_size = b.size;
					else if (pick == 2)
						w.alloc_size = '0;
				end
			end else begin
				w.mode = sae_pkg::MODE_FREE_ALL;
				live_blocks.delete();
			end
			send_word(w);
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		shadow_top  = '0;
		shadow_prev = '0;
		shadow_len  = 13'd4096;
		shadow_base = '0;
		foreach (shadow_hdr[i])
			shadow_hdr[i] = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_alloc_free();
		test_resize();
		test_buffer_edges();

		quiesce_for_config();
		set_config(13'd4096, 13'd0);
		test_random_traffic(PHASE_WORDS, 1'b1);
		quiesce_for_config();
		set_config(13'd1500, 13'd37);
		test_random_traffic(PHASE_WORDS, 1'b1);
		quiesce_for_config();
		set_config(13'd4096, 13'd127);
		test_random_traffic(PHASE_WORDS, 1'b1);
		quiesce_for_config();
		set_config(13'd300, 13'h1F81);
		test_random_traffic(PHASE_WORDS, 1'b1);
		quiesce_for_config();
		set_config(13'd0, 13'd64);
		test_random_traffic(PHASE_WORDS / 3, 1'b1);
		quiesce_for_config();
		set_config(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
		test_random_traffic(PHASE_WORDS, 1'b1);
		quiesce_for_config();
		set_config(13'd4096, 13'($urandom_range(0, 127)));
		test_random_traffic(PHASE_WORDS, 1'b0);

		// drain, then give the engine time to show any stray word
		hold_until_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_outcomes.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
